### rtl/pfdb_pkg.sv
// Package for the packed-pixel framebuffer with dirty box.
// Holds sizes, derived widths, opcode and register codes, and beat types.
// No dependencies.
package pfdb_pkg;

  localparam int MEM_WORDS = 16384;
  localparam int MAX_DIM   = 4096;

  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int LIN_W  = 2 * DIM_W;
  localparam int BIT_W  = LIN_W + 4;
  localparam int WORD_W = BIT_W - 5;

  localparam logic [15:0] GREEN_MASK = 16'b0000011111100000;
  localparam logic [4:0]  OFFSET_MASK = 5'b11111;
  localparam int          TOP_SHIFT  = 24;
  localparam logic [14:0] SIZE_MAX15 = 15'h7FFF;

  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_BITS_PER_PIXEL = 2'd2;

  localparam logic [12:0] RESET_IMAGE_WIDTH    = 13'd800;
  localparam logic [12:0] RESET_IMAGE_HEIGHT   = 13'd600;
  localparam logic [3:0]  RESET_BITS_PER_PIXEL = 4'd1;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_DRAW  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         raw_value;
    logic [15:0]        rgb_color;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]         pixel_value;
    logic               box_valid;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
  } out_beat_t;

endpackage

### rtl/packed_pixel_framebuffer_dirty_box.sv
// Top level of the packed-pixel framebuffer with dirty bounding box.
// Holds the pixel word memory, the read-modify-write sequencer, the box and the APB registers.
// Depends on pfdb_pkg.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  in_data  (in_beat_t)
//   out       source     out_valid/ out_stall out_data (out_beat_t)
//   cfg       APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// Each item passes through an accept step with the row*width+column product, then the
// bpp multiply and memory read, then the word modify/write-back and result load.
// The single-port word memory with its registered read sets these steps.
// A result waits in the output register; the next item is accepted meanwhile and
// holds in its last step only while the previous result is still stalled.
// Reset (rst, synchronous) empties the box, restores 800x600 at 1 bpp and leaves
// the pixel memory as it was; no clearing pass is run.
module packed_pixel_framebuffer_dirty_box
  import pfdb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADDR = 3'b010,
    ST_DATA = 3'b100
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [12:0] image_width, image_height;
  logic [3:0]  bits_per_pixel;

  // Item held through the sequence.
  in_beat_t          item;
  logic              in_bitmap;
  logic [LIN_W-1:0]  lin;
  logic              hit;
  logic [4:0]        offset;
  logic [ADDR_W-1:0] word_addr;

  // Box state.
  logic signed [15:0] dirty_left, dirty_top;
  logic [14:0]        dirty_width, dirty_height;
  logic               dirty_empty;

  // Memory.
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rdata;
  logic        mem_rd, mem_wr;
  logic [31:0] wdata;

  // Effective geometry.
  logic [DIM_W-1:0] eff_w, eff_h;
  logic [3:0]       eff_bpp;

  logic accept, advance;

  assign pready = 1'b1;

  always_comb begin
    eff_w = (16'(image_width) > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(image_width);
    eff_h = (16'(image_height) > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(image_height);
    if (bits_per_pixel == 4'd0) begin
      eff_bpp = 4'd1;
    end else if (bits_per_pixel > 4'd8) begin
      eff_bpp = 4'd8;
    end else begin
      eff_bpp = bits_per_pixel;
    end
  end

  // APB registers: write on the access phase, read back combinationally.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RESET_IMAGE_WIDTH;
      image_height   <= RESET_IMAGE_HEIGHT;
      bits_per_pixel <= RESET_BITS_PER_PIXEL;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_IMAGE_WIDTH:    image_width    <= pwdata[12:0];
        REG_IMAGE_HEIGHT:   image_height   <= pwdata[12:0];
        REG_BITS_PER_PIXEL: bits_per_pixel <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_WIDTH:    prdata = {19'd0, image_width};
      REG_IMAGE_HEIGHT:   prdata = {19'd0, image_height};
      REG_BITS_PER_PIXEL: prdata = {28'd0, bits_per_pixel};
      default:            prdata = 32'd0;
    endcase
  end

  // Sequencer.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign advance  = (state == ST_DATA) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept)  state_next = ST_ADDR;
      ST_ADDR:              state_next = ST_DATA;
      ST_DATA: if (advance) state_next = ST_IDLE;
      default:              state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accept step: bounds check and linear pixel index.
  logic             in_bitmap_next;
  logic [LIN_W-1:0] lin_next;

  always_comb begin
    in_bitmap_next = !in_data.pos_x[15] && !in_data.pos_y[15]
                  && ({1'b0, in_data.pos_x[14:0]} < 16'(eff_w))
                  && ({1'b0, in_data.pos_y[14:0]} < 16'(eff_h));
    // Truncation is exact whenever the pixel is in the bitmap.
    lin_next = LIN_W'(in_data.pos_y[DIM_W-1:0]) * LIN_W'(eff_w)
             + LIN_W'(in_data.pos_x[DIM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= in_data;
      in_bitmap <= in_bitmap_next;
      lin       <= lin_next;
    end
  end

  // Address step: bit index, word range check, memory read.
  logic [BIT_W-1:0]  bit_index;
  logic [WORD_W-1:0] word_index;

  always_comb begin
    bit_index  = BIT_W'(lin) * BIT_W'(eff_bpp);
    word_index = bit_index[BIT_W-1:5];
  end

  assign mem_rd = (state == ST_ADDR);

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      hit       <= in_bitmap && (word_index < WORD_W'(MEM_WORDS));
      offset    <= bit_index[4:0] & OFFSET_MASK;
      word_addr <= bit_index[ADDR_W+4:5];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[word_addr] <= wdata;
    end
    if (mem_rd) begin
      rdata <= mem[bit_index[ADDR_W+4:5]];
    end
  end

  // Data step: extract or merge the pixel bits.
  logic [31:0] top_mask, word_mask, new_bits;
  logic [7:0]  wr_byte, rd_byte;
  logic [31:0] rd_shift;

  always_comb begin
    top_mask  = 32'hFFFF_FFFF << (6'd32 - 6'(eff_bpp));
    word_mask = top_mask >> offset;
    wr_byte   = (item.opcode == OP_DRAW) ? 8'((item.rgb_color & GREEN_MASK) >> 3)
                                         : item.raw_value;
    new_bits  = (({wr_byte, 24'd0}) & top_mask) >> offset;
    wdata     = (rdata & ~word_mask) | new_bits;
    rd_shift  = ((rdata << offset) & top_mask) >> TOP_SHIFT;
    rd_byte   = rd_shift[7:0];
    mem_wr    = advance && hit
             && ((item.opcode == OP_WRITE) || (item.opcode == OP_DRAW));
  end

  // Box growth; the far edges come from the stored, saturated size.
  logic signed [18:0] x_ext, y_ext, right, bottom, left_n, top_n, w_raw, h_raw;
  logic [14:0]        w_sat, h_sat;

  always_comb begin
    x_ext  = 19'(item.pos_x);
    y_ext  = 19'(item.pos_y);
    right  = 19'(dirty_left) + 19'(signed'({4'd0, dirty_width})) - 19'sd1;
    bottom = 19'(dirty_top) + 19'(signed'({4'd0, dirty_height})) - 19'sd1;
    left_n = (x_ext < 19'(dirty_left)) ? x_ext : 19'(dirty_left);
    top_n  = (y_ext < 19'(dirty_top)) ? y_ext : 19'(dirty_top);
    if (x_ext > right) right = x_ext;
    if (y_ext > bottom) bottom = y_ext;
    w_raw = right - left_n + 19'sd1;
    h_raw = bottom - top_n + 19'sd1;
    priority if (w_raw < 0) w_sat = 15'd0;
    else if (w_raw > 19'(SIZE_MAX15)) w_sat = SIZE_MAX15;
    else w_sat = w_raw[14:0];
    priority if (h_raw < 0) h_sat = 15'd0;
    else if (h_raw > 19'(SIZE_MAX15)) h_sat = SIZE_MAX15;
    else h_sat = h_raw[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_left   <= '0;
      dirty_top    <= '0;
      dirty_width  <= '0;
      dirty_height <= '0;
      dirty_empty  <= 1'b1;
    end else if (advance) begin
      if (item.opcode == OP_CLEAR) begin
        dirty_left   <= '0;
        dirty_top    <= '0;
        dirty_width  <= '0;
        dirty_height <= '0;
        dirty_empty  <= 1'b1;
      end else if (item.opcode == OP_DRAW) begin
        if (dirty_empty) begin
          dirty_left   <= item.pos_x;
          dirty_top    <= item.pos_y;
          dirty_width  <= 15'd1;
          dirty_height <= 15'd1;
          dirty_empty  <= 1'b0;
        end else begin
          dirty_left   <= left_n[15:0];
          dirty_top    <= top_n[15:0];
          dirty_width  <= w_sat;
          dirty_height <= h_sat;
        end
      end
    end
  end

  // Result: the box fields show the state after the step.
  out_beat_t result;

  always_comb begin
    result.pixel_value = (hit && (item.opcode == OP_READ)) ? rd_byte : 8'd0;
    unique case (item.opcode)
      OP_CLEAR: begin
        result.box_valid  = 1'b0;
        result.box_left   = '0;
        result.box_top    = '0;
        result.box_width  = '0;
        result.box_height = '0;
      end
      OP_DRAW: begin
        result.box_valid  = 1'b1;
        result.box_left   = dirty_empty ? item.pos_x : left_n[15:0];
        result.box_top    = dirty_empty ? item.pos_y : top_n[15:0];
        result.box_width  = dirty_empty ? 15'd1 : w_sat;
        result.box_height = dirty_empty ? 15'd1 : h_sat;
      end
      default: begin
        result.box_valid  = !dirty_empty;
        result.box_left   = dirty_left;
        result.box_top    = dirty_top;
        result.box_width  = dirty_width;
        result.box_height = dirty_height;
      end
    endcase
  end

  // Output register: load on advance, drop on an unstalled beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

### dv/pfdb_checker.sv
// Scoreboard for the packed-pixel framebuffer with dirty box: predicts one result beat
// per accepted input beat, compares field by field and checks register read-back.
// Depends on pfdb_pkg.
module pfdb_checker
  import pfdb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  bit [31:0]          shadow_words [MEM_WORDS];
  logic [12:0]        geo_width;
  logic [12:0]        geo_height;
  logic [3:0]         geo_bpp;
  logic signed [15:0] box_x0;
  logic signed [15:0] box_y0;
  logic [14:0]        box_w;
  logic [14:0]        box_h;
  logic               box_empty;
  out_beat_t          predicted_beats [$];
  int                 errs = 0;

  function automatic int clip_dim(input logic [12:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  function automatic int clip_bpp();
    if (geo_bpp == 0) return 1;
    return (geo_bpp > 8) ? 8 : int'(geo_bpp);
  endfunction

  function automatic logic [31:0] pixel_mask();
    return 32'hFFFF_FFFF << (32 - clip_bpp());
  endfunction

  // Word and bit offset of a pixel; zero when outside the bitmap or past the memory.
  function automatic bit find_slot(input logic signed [15:0] x, input logic signed [15:0] y,
                                   output int word, output int off);
    longint bitpos;
    word = 0;
    off  = 0;
    if (x < 0 || y < 0 || int'(x) >= clip_dim(geo_width) || int'(y) >= clip_dim(geo_height))
      return 1'b0;
    bitpos = (longint'(y) * clip_dim(geo_width) + longint'(x)) * clip_bpp();
    if ((bitpos >> 5) >= MEM_WORDS) return 1'b0;
    word = int'(bitpos >> 5);
    off  = int'(bitpos) & int'(OFFSET_MASK);
    return 1'b1;
  endfunction

  // Bits that would spill past the end of the word are simply lost.
  function automatic void store_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                                      input logic [7:0] value);
    int          word;
    int          off;
    logic [31:0] keep;
    keep = pixel_mask();
    if (!find_slot(x, y, word, off)) return;
    shadow_words[word] &= ~(keep >> off);
    shadow_words[word] |= ((32'(value) << TOP_SHIFT) & keep) >> off;
  endfunction

  function automatic logic [14:0] clamp15(input int v);
    if (v < 0) return '0;
    return (v > int'(SIZE_MAX15)) ? SIZE_MAX15 : 15'(v);
  endfunction

  // Right and bottom edges come from the stored, possibly saturated, size.
  function automatic void grow_box(input logic signed [15:0] x, input logic signed [15:0] y);
    int left;
    int top;
    int right;
    int bottom;
    if (box_empty) begin
      box_x0    = x;
      box_y0    = y;
      box_w     = 15'd1;
      box_h     = 15'd1;
      box_empty = 1'b0;
      return;
    end
    left   = int'(box_x0);
    top    = int'(box_y0);
    right  = left + int'(box_w) - 1;
    bottom = top + int'(box_h) - 1;
    if (int'(x) < left) left = int'(x);
    if (int'(y) < top) top = int'(y);
    if (int'(x) > right) right = int'(x);
    if (int'(y) > bottom) bottom = int'(y);
    box_x0 = 16'(left);
    box_y0 = 16'(top);
    box_w  = clamp15(right - left + 1);
    box_h  = clamp15(bottom - top + 1);
  endfunction

  function automatic void empty_box();
    box_x0    = '0;
    box_y0    = '0;
    box_w     = '0;
    box_h     = '0;
    box_empty = 1'b1;
  endfunction

  function automatic out_beat_t predict_beat(input in_beat_t b);
    out_beat_t r;
    int        word;
    int        off;
    r = '0;
    case (b.opcode)
      OP_READ: begin
        if (find_slot(b.pos_x, b.pos_y, word, off))
          r.pixel_value = 8'(((shadow_words[word] << off) & pixel_mask()) >> TOP_SHIFT);
      end
      OP_WRITE: store_pixel(b.pos_x, b.pos_y, b.raw_value);
      OP_DRAW: begin
        // green bits [10:5] land at the top of the luminance byte
        store_pixel(b.pos_x, b.pos_y, 8'((b.rgb_color & GREEN_MASK) >> 3));
        grow_box(b.pos_x, b.pos_y);
      end
      OP_CLEAR: empty_box();
      default: ;
    endcase
    r.box_valid  = !box_empty;
    r.box_left   = box_x0;
    r.box_top    = box_y0;
    r.box_width  = box_w;
    r.box_height = box_h;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t   want;
    logic [31:0] reg_now;
    bit          reg_known;
    if (rst) begin
      geo_width  = RESET_IMAGE_WIDTH;
      geo_height = RESET_IMAGE_HEIGHT;
      geo_bpp    = RESET_BITS_PER_PIXEL;
      empty_box();
      predicted_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_beats.size() == 0) begin
          $display("%0t: result beat with nothing predicted, got %h", $time, out_data);
          errs++;
        end else begin
          want = predicted_beats.pop_front();
          check_field("pixel_value", want.pixel_value, out_data.pixel_value);
          check_field("box_valid", want.box_valid, out_data.box_valid);
          check_field("box_left", want.box_left, out_data.box_left);
          check_field("box_top", want.box_top, out_data.box_top);
          check_field("box_width", want.box_width, out_data.box_width);
          check_field("box_height", want.box_height, out_data.box_height);
        end
      end
      if (psel && penable && pready) begin
        reg_known = 1'b1;
        reg_now   = '0;
        case (paddr[3:2])
          REG_IMAGE_WIDTH:    reg_now = 32'(geo_width);
          REG_IMAGE_HEIGHT:   reg_now = 32'(geo_height);
          REG_BITS_PER_PIXEL: reg_now = 32'(geo_bpp);
          default:            reg_known = 1'b0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_IMAGE_WIDTH:    geo_width  = pwdata[12:0];
            REG_IMAGE_HEIGHT:   geo_height = pwdata[12:0];
            REG_BITS_PER_PIXEL: geo_bpp    = pwdata[3:0];
            default: ;
          endcase
        end else if (reg_known && prdata !== reg_now) begin
          $display("%0t: register %0d read expected %h, got %h", $time, paddr[3:2],
                   reg_now, prdata);
          errs++;
        end
      end
      if (in_valid && !in_stall) predicted_beats.push_back(predict_beat(in_data));
    end
    pending    <= predicted_beats.size();
    fail_count <= errs;
  end

endmodule

### dv/tb_top.sv
// Top of the framebuffer testbench: clock, reset, APB setup, input beats and output stalls.
// Instantiates packed_pixel_framebuffer_dirty_box and pfdb_checker; depends on pfdb_pkg.
module tb_top;
  import pfdb_pkg::*;

  // index past the register list; writes there must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  // Stimulus-side bookkeeping. The pixel memory has no reset, so track which bits have
  // been written and steer reads away from any pixel holding never-written bits.
  bit [31:0]   written_bits [MEM_WORDS];
  logic [12:0] set_width;
  logic [12:0] set_height;
  logic [3:0]  set_bpp;
  in_beat_t    recent_writes [$];
  bit          gaps_on;
  bit          stall_on;

  packed_pixel_framebuffer_dirty_box u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pfdb_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, even with every long stall stacked up.
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle length: mostly zero or a few cycles, now and then a long stretch.
  function automatic int pause_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Output stall: random runs of stall or no stall while stall_on is set.
  initial begin : stall_gen
    int run;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      out_stall <= stall_on && ($urandom_range(0, 2) == 0);
      run = 1 + pause_len();
      repeat (run) @(posedge clk);
    end
  end

  function automatic int dim_eff(input logic [12:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // Word and bit span a pixel touches under the current geometry; zero when the access
  // falls outside the bitmap or past the memory (such a read returns 0 and is safe).
  function automatic bit pixel_span(input logic signed [15:0] x, input logic signed [15:0] y,
                                    output int word, output logic [31:0] span);
    int     w;
    int     h;
    int     bpp;
    longint bitpos;
    w    = dim_eff(set_width);
    h    = dim_eff(set_height);
    bpp  = (set_bpp == 0) ? 1 : (set_bpp > 8) ? 8 : int'(set_bpp);
    word = 0;
    span = '0;
    if (x < 0 || y < 0 || int'(x) >= w || int'(y) >= h) return 1'b0;
    bitpos = (longint'(y) * w + longint'(x)) * bpp;
    if ((bitpos >> 5) >= MEM_WORDS) return 1'b0;
    word = int'(bitpos >> 5);
    span = (32'hFFFF_FFFF << (32 - bpp)) >> (int'(bitpos) & int'(OFFSET_MASK));
    return 1'b1;
  endfunction

  // Coordinate around a bitmap edge of the given size; now and then anywhere in 16 bits.
  function automatic logic signed [15:0] near_coord(input int size);
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'($urandom);
    if (p == 1) return 16'(size - int'($urandom_range(0, 1)));
    if (size > 64 && p < 6) return 16'($urandom_range(0, 63));
    return 16'(int'($urandom_range(0, size + 1)) - 1);
  endfunction

  // Random beat. Reads mostly revisit recent writes so data comes back through the
  // memory; a read that would touch unwritten bits is pushed left of the bitmap.
  function automatic in_beat_t make_item();
    in_beat_t    b;
    in_beat_t    prior;
    int          p;
    int          word;
    logic [31:0] span;
    b.raw_value = 8'($urandom);
    b.rgb_color = 16'($urandom);
    p = $urandom_range(0, 99);
    if (p < 35) b.opcode = OP_READ;
    else if (p < 62) b.opcode = OP_WRITE;
    else if (p < 96) b.opcode = OP_DRAW;
    else b.opcode = OP_CLEAR;
    b.pos_x = near_coord(dim_eff(set_width));
    b.pos_y = near_coord(dim_eff(set_height));
    if (b.opcode == OP_READ) begin
      if (recent_writes.size() != 0 && $urandom_range(0, 9) < 6) begin
        prior   = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
        b.pos_x = prior.pos_x;
        b.pos_y = prior.pos_y;
      end
      if (pixel_span(b.pos_x, b.pos_y, word, span) && (written_bits[word] & span) != span)
        b.pos_x = -16'sd1 - 16'($urandom_range(0, 255));
    end
    return b;
  endfunction

  // Present one beat and hold it until accepted. With no gap, valid stays high and
  // only the payload advances, so valid gets a single update per step.
  task automatic send_item(input in_beat_t b);
    int          gap;
    int          word;
    logic [31:0] span;
    gap = gaps_on ? pause_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    if ((b.opcode == OP_WRITE || b.opcode == OP_DRAW) && pixel_span(b.pos_x, b.pos_y, word, span)) begin
      written_bits[word] |= span;
      recent_writes.push_back(b);
      if (recent_writes.size() > 48) void'(recent_writes.pop_front());
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(input opcode_t op, input int x, input int y, input int raw,
                             input int rgb);
    in_beat_t b;
    b.opcode    = op;
    b.pos_x     = 16'(x);
    b.pos_y     = 16'(y);
    b.raw_value = 8'(raw);
    b.rgb_color = 16'(rgb);
    send_item(b);
  endtask

  // Drop valid and hold off until every predicted beat has come back, then let the
  // pipeline settle before anything touches the registers.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup, then access until pready, then back to idle.
  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three registers with random junk above the field, then read them back.
  task automatic set_geometry(input int w, input int h, input int bpp);
    logic [31:0] junk;
    junk = $urandom;
    apb_access(1'b1, REG_IMAGE_WIDTH, {junk[31:13], 13'(w)});
    junk = $urandom;
    apb_access(1'b1, REG_IMAGE_HEIGHT, {junk[31:13], 13'(h)});
    junk = $urandom;
    apb_access(1'b1, REG_BITS_PER_PIXEL, {junk[31:4], 4'(bpp)});
    set_width  = 13'(w);
    set_height = 13'(h);
    set_bpp    = 4'(bpp);
    recent_writes.delete();
    apb_access(1'b0, REG_IMAGE_WIDTH, '0);
    apb_access(1'b0, REG_IMAGE_HEIGHT, '0);
    apb_access(1'b0, REG_BITS_PER_PIXEL, '0);
  endtask

  // Mostly small bitmaps so pixels land in memory; sometimes zero, the maximum, or
  // a value above the maximum that the block must clip.
  function automatic int pick_dim();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 0;
    if (p == 1) return MAX_DIM;
    if (p == 2) return $urandom_range(MAX_DIM + 1, 8191);
    if (p < 5) return $urandom_range(65, MAX_DIM);
    return $urandom_range(1, 40);
  endfunction

  initial begin : stimulus
    int phase;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    gaps_on    = 1'b1;
    stall_on   = 1'b1;
    set_width  = RESET_IMAGE_WIDTH;
    set_height = RESET_IMAGE_HEIGHT;
    set_bpp    = RESET_BITS_PER_PIXEL;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry read back: 800x600 at 1 bpp.
    apb_access(1'b0, REG_IMAGE_WIDTH, '0);
    apb_access(1'b0, REG_IMAGE_HEIGHT, '0);
    apb_access(1'b0, REG_BITS_PER_PIXEL, '0);

    // Directed, reset geometry: clear on an empty box, corner pixels, reads just
    // outside the right, left and bottom edges, a dropped negative write, then a box
    // spanning the whole 16-bit range so width and height saturate.
    send_fields(OP_CLEAR, 0, 0, 0, 0);
    send_fields(OP_WRITE, 0, 0, 8'hFF, 0);
    send_fields(OP_READ, 0, 0, 0, 0);
    send_fields(OP_WRITE, 799, 599, 8'h00, 16'hFFFF);
    send_fields(OP_READ, 799, 599, 8'hFF, 16'hFFFF);
    send_fields(OP_READ, 800, 0, 0, 0);
    send_fields(OP_READ, -1, 0, 0, 0);
    send_fields(OP_READ, 0, 600, 0, 0);
    send_fields(OP_WRITE, -32768, 5, 8'hFF, 0);
    send_fields(OP_DRAW, -32768, -32768, 0, 16'hFFFF);
    send_fields(OP_DRAW, 32767, 32767, 0, 16'h07E0);
    send_fields(OP_DRAW, 0, 0, 8'hFF, 16'hF81F);
    send_fields(OP_READ, 0, 0, 0, 0);
    send_fields(OP_CLEAR, 0, 0, 0, 0);
    send_fields(OP_DRAW, 5, 5, 0, 16'h0020);
    send_fields(OP_READ, 5, 5, 0, 0);
    drain();

    // Largest bitmap at 8 bpp: row 16 onward lies past the end of the memory.
    set_geometry(MAX_DIM, MAX_DIM, 8);
    send_fields(OP_WRITE, 3, 15, 8'hA5, 0);
    send_fields(OP_READ, 3, 15, 0, 0);
    send_fields(OP_WRITE, 4095, 4095, 8'hFF, 0);
    send_fields(OP_READ, 4095, 4095, 0, 0);
    send_fields(OP_READ, 0, 16, 0, 0);
    drain();

    // Ignored register index, width above the limit, zero height, zero bpp.
    apb_access(1'b1, REG_UNUSED, $urandom);
    set_geometry(8191, 0, 0);
    send_fields(OP_READ, 0, 0, 0, 0);
    send_fields(OP_WRITE, 0, 0, 8'hFF, 0);
    send_fields(OP_DRAW, 2, 3, 0, 16'hFFFF);
    drain();

    // 7 bpp: pixel 4 of row 0 starts at bit 28 and straddles the word boundary.
    set_geometry(11, 7, 7);
    send_fields(OP_WRITE, 4, 0, 8'hFE, 0);
    send_fields(OP_READ, 4, 0, 0, 0);
    drain();

    // Random phases. The first three pin the register extremes; idling cycles through
    // none, sender gaps only, receiver stalls only, and both.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       set_geometry(1, 1, 8);
        1:       set_geometry(8191, 8191, 15);
        2:       set_geometry(0, 40, 3);
        default: set_geometry(pick_dim(), pick_dim(), $urandom_range(0, 15));
      endcase
      gaps_on  = phase[0];
      stall_on = phase[1];
      repeat (88) send_item(make_item());
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
